// File: rtl/core/assert_macros.svh
// assertion helpers for the rtl files; tevq_ctrl includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check with a fixed clk_i and rst_ni
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/tevq_pkg.sv
package tevq_pkg;

  // width of one coordinate or pressure value
  localparam int unsigned FieldW = 10;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // wire mode codes
  localparam logic MODE_FOUR_WIRE = 1'b0;
  localparam logic MODE_FIVE_WIRE = 1'b1;

  // one queued touch event
  typedef struct packed {
    logic [FieldW-1:0] x;
    logic [FieldW-1:0] y;
    logic [FieldW-1:0] press;
  } event_t;

  // result control from the queue controller
  typedef struct packed {
    logic strobe;
    logic valid;
    logic empty;
  } res_ctrl_t;

endpackage

// File: rtl/core/tevq_ram.sv
module tevq_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/tevq_ctrl.sv
`include "assert_macros.svh"

module tevq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          operation_i,
  input  logic [tevq_pkg::FieldW-1:0]   x_pos_i,
  input  logic [tevq_pkg::FieldW-1:0]   y_pos_i,
  input  logic [tevq_pkg::FieldW-1:0]   press_level_i,
  input  logic                          pen_lifted_i,
  input  logic                          wire_mode_i,
  output logic                          wr_en_o,
  output logic [PTR_W-1:0]              wr_addr_o,
  output tevq_pkg::event_t              wr_data_o,
  output logic [PTR_W-1:0]              rd_addr_o,
  output tevq_pkg::res_ctrl_t           res_o
);

  localparam logic [PTR_W-1:0] LastIdx = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic             contact_q, contact_d;
  tevq_pkg::res_ctrl_t res_q, res_d;

  logic [PTR_W-1:0] head_next, tail_next;
  logic             is_push, is_pop, empty_now, ring_full;
  tevq_pkg::event_t ev;

  // ring successors
  assign head_next = (head_q == LastIdx) ? '0 : head_q + PTR_W'(1);
  assign tail_next = (tail_q == LastIdx) ? '0 : tail_q + PTR_W'(1);

  assign is_push   = accept_i && (operation_i == tevq_pkg::OP_PUSH);
  assign is_pop    = accept_i && (operation_i == tevq_pkg::OP_POP);
  assign empty_now = (head_q == tail_q);
  assign ring_full = (tail_next == head_q);

  // event built from one touch sample
  always_comb begin
    ev.x = x_pos_i;
    ev.y = y_pos_i;
    if (wire_mode_i == tevq_pkg::MODE_FIVE_WIRE) begin
      ev.press = {{(tevq_pkg::FieldW-1){1'b0}}, !pen_lifted_i};
    end else begin
      ev.press = press_level_i;
    end
    if (pen_lifted_i && contact_q) begin
      ev = '0;
    end
  end

  // pointer, contact and result control update
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    contact_d = contact_q;
    res_d     = '0;
    if (is_push) begin
      if (!ring_full) begin
        tail_d = tail_next;
      end
      if (!pen_lifted_i) begin
        contact_d = 1'b1;
      end else begin
        contact_d = 1'b0;
      end
    end else if (is_pop && !empty_now) begin
      head_d    = head_next;
      res_d.valid = 1'b1;
    end
    res_d.strobe = accept_i;
    res_d.empty  = (head_d == tail_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      contact_q <= 1'b0;
      res_q     <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      contact_q <= contact_d;
      res_q     <= res_d;
    end
  end

  // memory ports
  assign wr_en_o   = is_push;
  assign wr_addr_o = tail_q;
  assign wr_data_o = ev;
  assign rd_addr_o = head_q;
  assign res_o     = res_q;

  // checks
  `ASSERT_STD(a_beat_gives_result, accept_i |=> res_q.strobe, "beat gave no result")
  `ASSERT_STD(a_valid_has_strobe, res_q.valid |-> res_q.strobe, "valid without strobe")
  `ASSERT_STD(a_full_hold, (is_push && ring_full) |=> $stable({head_q, tail_q}), "ptr moved")
  `ASSERT_STD(a_pop_head, (is_pop && !empty_now) |=> head_q == $past(head_next), "head stuck")

endmodule

// File: rtl/core/touch_event_ring_queue_unit.sv
// touch event queue: a ring of QUEUE_DEPTH slots holding at most
// QUEUE_DEPTH-1 events; a push into a full ring is lost.
// input channel: a beat is taken at a rising edge with start_i high and
// busy_o low; busy_o stays low, so one push or pop can be issued in
// every cycle. operation_i selects push of a touch sample or pop.
// result channel: every beat gives one result in the cycle after it, shown
// for exactly one cycle with done_o high. the result is registered, in
// step with the registered read port of the event memory; throughput is
// one beat per cycle. the receiver cannot stall; results are not held.
// event_valid_o marks a pop that returned an event; a push or a pop of
// an empty queue returns zero fields. queue_empty_o gives the queue
// state after the beat.
// configuration: cfg_data_i is the wire mode (0 four-wire, 1 five-wire),
// written when cfg_valid_i is high; cfg_ready_o is always high.
// reset: head, tail, contact mark and wire mode clear, no result is
// pending; the event memory is not cleared and needs no clearing pass.
module touch_event_ring_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        operation_i,
  input  logic [tevq_pkg::FieldW-1:0] x_pos_i,
  input  logic [tevq_pkg::FieldW-1:0] y_pos_i,
  input  logic [tevq_pkg::FieldW-1:0] press_level_i,
  input  logic                        pen_lifted_i,
  output logic                        done_o,
  output logic                        event_valid_o,
  output logic [tevq_pkg::FieldW-1:0] event_x_o,
  output logic [tevq_pkg::FieldW-1:0] event_y_o,
  output logic [tevq_pkg::FieldW-1:0] event_press_o,
  output logic                        queue_empty_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned EvW  = $bits(tevq_pkg::event_t);

  logic                wire_mode_q;
  logic                accept;
  logic                wr_en;
  logic [PtrW-1:0]     wr_addr, rd_addr;
  tevq_pkg::event_t    wr_data, rd_data;
  logic [EvW-1:0]      rd_bits;
  tevq_pkg::res_ctrl_t res;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // wire mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wire_mode_q <= tevq_pkg::MODE_FOUR_WIRE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wire_mode_q <= cfg_data_i;
    end
  end

  tevq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .press_level_i (press_level_i),
    .pen_lifted_i  (pen_lifted_i),
    .wire_mode_i   (wire_mode_q),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_addr_o     (rd_addr),
    .res_o         (res)
  );

  tevq_ram #(
    .WIDTH (EvW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_bits)
  );

  // result fields are zero unless a pop returned an event
  assign rd_data       = rd_bits;
  assign done_o        = res.strobe;
  assign event_valid_o = res.valid;
  assign event_x_o     = res.valid ? rd_data.x : '0;
  assign event_y_o     = res.valid ? rd_data.y : '0;
  assign event_press_o = res.valid ? rd_data.press : '0;
  assign queue_empty_o = res.empty;

endmodule

// File: tb/touch_event_ring_queue_unit_tb.sv
module touch_event_ring_queue_unit_tb;

  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PRINT_LIMIT = 20;
  localparam int unsigned FW = tevq_pkg::FieldW;

  // one result beat as seen on the output ports
  typedef struct packed {
    logic          valid;
    logic [FW-1:0] x;
    logic [FW-1:0] y;
    logic [FW-1:0] press;
    logic          empty;
  } touch_result_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  logic          operation_i;
  logic [FW-1:0] x_pos_i;
  logic [FW-1:0] y_pos_i;
  logic [FW-1:0] press_level_i;
  logic          pen_lifted_i;
  logic          done_o;
  logic          event_valid_o;
  logic [FW-1:0] event_x_o;
  logic [FW-1:0] event_y_o;
  logic [FW-1:0] event_press_o;
  logic          queue_empty_o;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic          cfg_data_i;

  touch_event_ring_queue_unit #(
    .QUEUE_DEPTH(RING_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .press_level_i(press_level_i),
    .pen_lifted_i (pen_lifted_i),
    .done_o       (done_o),
    .event_valid_o(event_valid_o),
    .event_x_o    (event_x_o),
    .event_y_o    (event_y_o),
    .event_press_o(event_press_o),
    .queue_empty_o(queue_empty_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // shadow copy of the ring and its control state
  tevq_pkg::event_t ring_model [RING_DEPTH];
  int unsigned      head_idx;
  int unsigned      tail_idx;
  logic             contact_model;
  logic             mode_model;
  touch_result_t    pending_results[$];

  int unsigned error_count;
  int unsigned item_count;
  int unsigned cfg_write_count;
  int unsigned event_pop_count;
  int unsigned overwrite_count;
  int unsigned pen_off_count;
  int unsigned cycle_count;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("mismatch %s: got %0d expected %0d (item %0d)", what, got, want,
               item_count);
  endtask

  // next result of the queue for one accepted beat, updates the shadow state
  function automatic touch_result_t step_touch_model(input logic op,
                                                     input logic [FW-1:0] x,
                                                     input logic [FW-1:0] y,
                                                     input logic [FW-1:0] p,
                                                     input logic lifted);
    touch_result_t    res;
    tevq_pkg::event_t ev;
    int unsigned      nxt;
    res = '0;
    if (op == tevq_pkg::OP_PUSH) begin
      ev.x = x;
      ev.y = y;
      if (mode_model == tevq_pkg::MODE_FIVE_WIRE)
        ev.press = {{(FW-1){1'b0}}, ~lifted};
      else
        ev.press = p;
      // lifting after contact queues a pen-off marker
      if (lifted) begin
        if (contact_model) begin
          ev = '0;
          contact_model = 1'b0;
          pen_off_count++;
        end
      end else begin
        contact_model = 1'b1;
      end
      ring_model[tail_idx] = ev;
      nxt = (tail_idx + 1) % RING_DEPTH;
      if (nxt != head_idx)
        tail_idx = nxt;
      else
        overwrite_count++;
    end else if (head_idx != tail_idx) begin
      res.valid = 1'b1;
      res.x     = ring_model[head_idx].x;
      res.y     = ring_model[head_idx].y;
      res.press = ring_model[head_idx].press;
      head_idx  = (head_idx + 1) % RING_DEPTH;
      event_pop_count++;
    end
    res.empty = (head_idx == tail_idx);
    return res;
  endfunction

  // result checking and prediction on every rising edge
  always @(posedge clk_i) begin
    touch_result_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (event_valid_o !== want.valid)
            report_mismatch("event_valid", 32'(event_valid_o), 32'(want.valid));
          if (event_x_o !== want.x)
            report_mismatch("event_x", 32'(event_x_o), 32'(want.x));
          if (event_y_o !== want.y)
            report_mismatch("event_y", 32'(event_y_o), 32'(want.y));
          if (event_press_o !== want.press)
            report_mismatch("event_press", 32'(event_press_o), 32'(want.press));
          if (queue_empty_o !== want.empty)
            report_mismatch("queue_empty", 32'(queue_empty_o), 32'(want.empty));
        end
      end
      if (cfg_valid_i && cfg_ready_o)
        mode_model = cfg_data_i;
      if (start_i && !busy_o)
        pending_results.push_back(step_touch_model(operation_i, x_pos_i, y_pos_i,
                                                   press_level_i, pen_lifted_i));
    end
  end

  // one input beat, held until taken
  task automatic send_touch(input logic op, input logic [FW-1:0] x,
                            input logic [FW-1:0] y, input logic [FW-1:0] p,
                            input logic lifted);
    @(negedge clk_i);
    start_i       <= 1'b1;
    operation_i   <= op;
    x_pos_i       <= x;
    y_pos_i       <= y;
    press_level_i <= p;
    pen_lifted_i  <= lifted;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    item_count++;
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // let every pending result arrive
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // wire mode write while the queue is quiet
  task automatic write_wire_mode(input logic mode);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_write_count++;
  endtask

  // converter value biased toward the extremes
  function automatic logic [FW-1:0] rand_field();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0)
      return '0;
    else if (pick == 1)
      return '1;
    else
      return FW'($urandom_range(0, (1 << FW) - 1));
  endfunction

  task automatic send_random(input int unsigned pop_pct, input int unsigned lift_pct,
                             input bit allow_idle);
    logic op;
    logic lifted;
    if (allow_idle && $urandom_range(0, 7) == 0)
      idle_cycles($urandom_range(1, 6));
    op     = ($urandom_range(0, 99) < pop_pct) ? tevq_pkg::OP_POP : tevq_pkg::OP_PUSH;
    lifted = ($urandom_range(0, 99) < lift_pct);
    send_touch(op, rand_field(), rand_field(), rand_field(), lifted);
  endtask

  // pop of an empty queue straight after reset
  task automatic test_empty_after_reset();
    send_touch(tevq_pkg::OP_POP, '1, '1, '1, 1'b1);
    send_touch(tevq_pkg::OP_POP, '0, '0, '0, 1'b0);
  endtask

  // four-wire: contact, pen-off after contact, lift without contact
  task automatic test_four_wire_directed();
    write_wire_mode(tevq_pkg::MODE_FOUR_WIRE);
    send_touch(tevq_pkg::OP_PUSH, '0, '0, '0, 1'b0);
    send_touch(tevq_pkg::OP_PUSH, '1, '1, '1, 1'b0);
    send_touch(tevq_pkg::OP_PUSH, 10'd300, 10'd400, 10'd500, 1'b1);
    send_touch(tevq_pkg::OP_PUSH, '1, 10'd512, '1, 1'b1);
    repeat (5) send_touch(tevq_pkg::OP_POP, '0, '0, '0, 1'b0);
  endtask

  // five-wire: pressure follows the contact flag
  task automatic test_five_wire_directed();
    write_wire_mode(tevq_pkg::MODE_FIVE_WIRE);
    send_touch(tevq_pkg::OP_PUSH, 10'd341, 10'd682, '1, 1'b0);
    send_touch(tevq_pkg::OP_PUSH, '1, '1, '1, 1'b1);
    send_touch(tevq_pkg::OP_PUSH, '1, '1, '1, 1'b1);
    repeat (4) send_touch(tevq_pkg::OP_POP, '1, '1, '1, 1'b1);
  endtask

  // fill, overwrite and drain phases in both modes, with idle bursts
  task automatic test_random_phases();
    int unsigned pop_pct;
    for (int seg = 0; seg < 10; seg++) begin
      write_wire_mode((seg % 4) < 2 ? tevq_pkg::MODE_FOUR_WIRE : tevq_pkg::MODE_FIVE_WIRE);
      case (seg % 3)
        0: pop_pct = 10;
        1: pop_pct = 70;
        default: pop_pct = 45;
      endcase
      repeat (140) send_random(pop_pct, 25, 1'b1);
    end
  endtask

  // back-to-back beats with no idling
  task automatic test_random_no_idle();
    write_wire_mode(logic'($urandom_range(0, 1)));
    for (int blk = 0; blk < 6; blk++)
      repeat (50) send_random((blk % 2) ? 75 : 15, 30, 1'b0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    operation_i     = tevq_pkg::OP_PUSH;
    x_pos_i         = '0;
    y_pos_i         = '0;
    press_level_i   = '0;
    pen_lifted_i    = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = tevq_pkg::MODE_FOUR_WIRE;
    head_idx        = 0;
    tail_idx        = 0;
    contact_model   = 1'b0;
    mode_model      = tevq_pkg::MODE_FOUR_WIRE;
    error_count     = 0;
    item_count      = 0;
    cfg_write_count = 0;
    event_pop_count = 0;
    overwrite_count = 0;
    pen_off_count   = 0;
    foreach (ring_model[i]) ring_model[i] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_after_reset();
    test_four_wire_directed();
    test_five_wire_directed();
    test_random_phases();
    test_random_no_idle();
    drain_results();

    if (pending_results.size() != 0)
      report_mismatch("results left outstanding", 0, unsigned'(pending_results.size()));

    $display("ran %0d beats with %0d wire mode writes, %0d events popped",
             item_count, cfg_write_count, event_pop_count);
    $display("full ring overwrites %0d, pen-off events %0d, mismatches %0d",
             overwrite_count, pen_off_count, error_count);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/tevq_pkg.sv
rtl/core/tevq_ram.sv
rtl/core/tevq_ctrl.sv
rtl/core/touch_event_ring_queue_unit.sv
tb/touch_event_ring_queue_unit_tb.sv
